// File: hw/rtl/assert_macros.svh
// assertion macros shared by the fixed-point alu rtl
// expects clk and arst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPA_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("%m: assertion failed");
`define FPA_NEVER(lbl, expr) lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("%m: forbidden condition seen");
`else
`define FPA_ASSERT(lbl, prop)
`define FPA_NEVER(lbl, expr)
`endif
`endif

// File: hw/rtl/fpa_pkg.sv
// shared types and constants of the fixed-point alu
// no dependencies
package fpa_pkg;
	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;
	localparam int DATA_BITS     = 32;
	localparam int DIV_STEP_BITS = 4;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INC, OP_DEC, OP_GT, OP_LT,
		OP_GE, OP_LE, OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_TO_INT, OP_FROM_INT
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_DZ   = 2'd2
	} err_t;

	typedef struct packed {
		opcode_t op;
		logic    neg;
		logic    a_neg;
		logic    dz;
		logic    cond;
		err_t    err;
	} ctl_t;
endpackage

// File: hw/rtl/fixed_point_alu_core.sv
// top level of the signed fixed-point alu: stream ports and stage chaining
// depends on fpa_pkg, assert_macros.svh, fpa_front, fpa_mul, fpa_div, fpa_pack
//
// usage
//  - a request enters on the s_ channel: s_tuser carries the opcode, s_tdata
//    the two raw operands; it is taken when s_tvalid and s_tready are high
//  - every request gives exactly one result on the m_ channel, in order:
//    m_tdata carries the raw result and the comparison flag, m_tuser the
//    error code (overflow saturated or divide by zero)
//  - every opcode passes the front stage, the multiplier stages, the
//    divider stages and the output stage, in that order; the divider
//    settles four quotient bits per stage
//  - throughput is one request per cycle while m_tready does not stall;
//    all opcodes share one pipe so results leave in request order
//  - each stage holds its own valid bit and loads when it is empty or its
//    successor moves, so a stall on m_tready fills empty stages first and
//    s_tready only drops once the whole pipe is full
//  - reset clears all valid bits: the pipe comes up empty with s_tready high
//  - no state outlives a request; nothing to configure
`include "assert_macros.svh"
module fixed_point_alu_core import fpa_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // operand_a [31:0], operand_b [63:32]
	input  logic [3:0]  s_tuser,  // opcode [3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // result_value [31:0], condition [32], zero pad [39:33]
	output logic [1:0]  m_tuser   // error_code [1:0]
);
	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int NS  = (W + F + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int NP  = NS * DIV_STEP_BITS;
	localparam int CW1 = $bits(ctl_t) + W;      // control and front-stage result
	localparam int CW2 = CW1 + W + 2;           // plus rounded product and its overflow

	// front stage outputs
	logic         fr_valid, fr_ready;
	ctl_t         fr_ctl;
	logic [W-1:0] fr_res, fr_mag_a, fr_mag_b;

	// multiplier outputs
	logic           mu_valid, mu_ready, mu_big;
	logic [W-1:0]   mu_mag_a, mu_mag_b;
	logic [CW1-1:0] mu_carry;
	logic [W:0]     mu_prod;

	// divider outputs
	logic           dv_valid, dv_ready;
	logic [NP-1:0]  dv_quot;
	logic [W-1:0]   dv_rem, dv_den;
	logic [CW2-1:0] dv_carry;

	// unpacked side data at the output stage
	ctl_t         pk_ctl;
	logic [W-1:0] pk_res;
	logic [W:0]   pk_prod;
	logic         pk_big;

	// result
	logic [W-1:0] out_res;
	logic         out_cond;
	err_t         out_err;

	fpa_front #(.W(W), .F(F)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (opcode_t'(s_tuser)),
		.in_a      (s_tdata[31:0]),
		.in_b      (s_tdata[63:32]),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_ctl   (fr_ctl),
		.out_res   (fr_res),
		.out_mag_a (fr_mag_a),
		.out_mag_b (fr_mag_b)
	);

	fpa_mul #(.W(W), .F(F), .CW(CW1)) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_mag_a  (fr_mag_a),
		.in_mag_b  (fr_mag_b),
		.in_carry  ({fr_ctl, fr_res}),
		.out_valid (mu_valid),
		.out_ready (mu_ready),
		.out_mag_a (mu_mag_a),
		.out_mag_b (mu_mag_b),
		.out_carry (mu_carry),
		.out_prod  (mu_prod),
		.out_big   (mu_big)
	);

	// the divider carries everything the output stage needs alongside the quotient
	fpa_div #(.W(W), .F(F), .K(DIV_STEP_BITS), .CW(CW2)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mu_valid),
		.in_ready  (mu_ready),
		.in_mag_a  (mu_mag_a),
		.in_mag_b  (mu_mag_b),
		.in_carry  ({mu_big, mu_prod, mu_carry}),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_quot  (dv_quot),
		.out_rem   (dv_rem),
		.out_den   (dv_den),
		.out_carry (dv_carry)
	);

	assign {pk_big, pk_prod, pk_ctl, pk_res} = dv_carry;

	fpa_pack #(.W(W), .NP(NP)) u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (dv_valid),
		.in_ready    (dv_ready),
		.in_ctl      (pk_ctl),
		.in_res      (pk_res),
		.in_mul_prod (pk_prod),
		.in_mul_big  (pk_big),
		.in_quot     (dv_quot),
		.in_rem      (dv_rem),
		.in_den      (dv_den),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (out_res),
		.out_cond    (out_cond),
		.out_err     (out_err)
	);

	// the word result is sign-extended or truncated onto the 32-bit field
	assign m_tdata = {7'b0, out_cond, DATA_BITS'($signed(out_res))};
	assign m_tuser = out_err;

	// input back-pressure only when every stage is full and the sink stalls
	`FPA_ASSERT(a_stall_only_full, (!s_tready |-> m_tvalid && !m_tready))
	`FPA_ASSERT(a_empty_out_ready, (!m_tvalid |-> s_tready))
	`FPA_NEVER(a_cmp_no_payload, m_tvalid && m_tdata[32] && (m_tuser != ERR_NONE || m_tdata[31:0] != '0))
endmodule

// File: hw/rtl/fpa_front.sv
// first stage: operand sizing, magnitudes and all operations other than multiply and divide
// depends on fpa_pkg
module fpa_front import fpa_pkg::*; #(
	parameter int W = WORD_BITS_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  opcode_t              in_op,
	input  logic [DATA_BITS-1:0] in_a,
	input  logic [DATA_BITS-1:0] in_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ctl_t                 out_ctl,
	output logic [W-1:0]         out_res,
	output logic [W-1:0]         out_mag_a,
	output logic [W-1:0]         out_mag_b
);
	localparam logic [W-1:0]   MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]   MIN_V = {1'b1, {(W-1){1'b0}}};
	localparam logic [W+F-1:0] LIM_X = (W+F)'(1) << (W-1);

	logic signed [W-1:0] a, b;
	logic [W-1:0]        mag_a, mag_b;
	logic [W:0]          add_w, sub_w, inc_w, dec_w, sel_w;
	logic [W+F-1:0]      fi_mag;
	logic                lt, eq, fi_ovf;
	ctl_t                ctl;
	logic [W-1:0]        res;
	logic                valid_s1;

	assign a     = W'($signed(in_a));
	assign b     = W'($signed(in_b));
	assign mag_a = a[W-1] ? W'(-a) : a;
	assign mag_b = b[W-1] ? W'(-b) : b;
	assign add_w = {a[W-1], a} + {b[W-1], b};
	assign sub_w = {a[W-1], a} - {b[W-1], b};
	assign inc_w = {a[W-1], a} + (W+1)'(1);
	assign dec_w = {a[W-1], a} - (W+1)'(1);
	assign lt    = a < b;
	assign eq    = a == b;
	assign fi_mag = (W+F)'(mag_a) << F;
	assign fi_ovf = a[W-1] ? (fi_mag > LIM_X) : (fi_mag > LIM_X - (W+F)'(1));

	always_comb begin
		ctl.op    = in_op;
		ctl.neg   = a[W-1] ^ b[W-1];
		ctl.a_neg = a[W-1];
		ctl.dz    = b == '0;
		ctl.cond  = 1'b0;
		ctl.err   = ERR_NONE;
		res       = '0;
		sel_w     = add_w;
		case (in_op)
			OP_SUB: sel_w = sub_w;
			OP_INC: sel_w = inc_w;
			OP_DEC: sel_w = dec_w;
			default: sel_w = add_w;
		endcase
		case (in_op) inside
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				// two's complement overflow when the two top bits differ
				if (sel_w[W] != sel_w[W-1]) begin
					res     = sel_w[W] ? MIN_V : MAX_V;
					ctl.err = ERR_OVF;
				end else begin
					res = sel_w[W-1:0];
				end
			end
			OP_GT: ctl.cond = !lt && !eq;
			OP_LT: ctl.cond = lt;
			OP_GE: ctl.cond = !lt;
			OP_LE: ctl.cond = lt || eq;
			OP_EQ: ctl.cond = eq;
			OP_NE: ctl.cond = !eq;
			OP_MIN: res = lt ? a : b;
			OP_MAX: res = lt ? b : a;
			OP_TO_INT: res = a >>> F;
			OP_FROM_INT: begin
				if (fi_ovf) begin
					res     = a[W-1] ? MIN_V : MAX_V;
					ctl.err = ERR_OVF;
				end else begin
					res = a[W-1] ? W'(-fi_mag) : fi_mag[W-1:0];
				end
			end
			default: res = '0;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_ctl   <= ctl;
			out_res   <= res;
			out_mag_a <= mag_a;
			out_mag_b <= mag_b;
		end
	end

	assign out_valid = valid_s1;
endmodule

// File: hw/rtl/fpa_mul.sv
// two-stage magnitude multiplier with rounding to the fraction lsb
// depends on fpa_pkg
module fpa_mul import fpa_pkg::*; #(
	parameter int W  = WORD_BITS_DEF,
	parameter int F  = FRAC_BITS_DEF,
	parameter int CW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [W-1:0]  in_mag_a,
	input  logic [W-1:0]  in_mag_b,
	input  logic [CW-1:0] in_carry,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [W-1:0]  out_mag_a,
	output logic [W-1:0]  out_mag_b,
	output logic [CW-1:0] out_carry,
	output logic [W:0]    out_prod,
	output logic          out_big
);
	localparam int H = (W + 1) / 2;
	localparam int L = W - H;
	localparam logic [2*W-1:0] RND = ((2*W)'(1) << F) >> 1;

	logic [2*H-1:0] ll_s2;
	logic [H+L-1:0] lh_s2, hl_s2;
	logic [2*L-1:0] hh_s2;
	logic [W-1:0]   mag_a_s2, mag_b_s2;
	logic [CW-1:0]  carry_s2;
	logic           valid_s2, valid_s3, ready_s2, ready_s3;
	logic [2*W-1:0] sum, sh;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = ready_s2;

	assign sum = (2*W)'(ll_s2) + ((2*W)'(lh_s2) << H) + ((2*W)'(hl_s2) << H)
		+ ((2*W)'(hh_s2) << (2*H)) + RND;
	assign sh = sum >> F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) valid_s2 <= in_valid;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && in_valid) begin
			ll_s2    <= in_mag_a[H-1:0] * in_mag_b[H-1:0];
			lh_s2    <= in_mag_a[H-1:0] * in_mag_b[W-1:H];
			hl_s2    <= in_mag_a[W-1:H] * in_mag_b[H-1:0];
			hh_s2    <= in_mag_a[W-1:H] * in_mag_b[W-1:H];
			mag_a_s2 <= in_mag_a;
			mag_b_s2 <= in_mag_b;
			carry_s2 <= in_carry;
		end
		if (ready_s3 && valid_s2) begin
			out_prod  <= sh[W:0];
			out_big   <= (sh >> (W + 1)) != '0;
			out_mag_a <= mag_a_s2;
			out_mag_b <= mag_b_s2;
			out_carry <= carry_s2;
		end
	end

	assign out_valid = valid_s3;
endmodule

// File: hw/rtl/fpa_div.sv
// pipelined restoring divider, K quotient bits per stage
// depends on fpa_pkg
module fpa_div import fpa_pkg::*; #(
	parameter int W  = WORD_BITS_DEF,
	parameter int F  = FRAC_BITS_DEF,
	parameter int K  = DIV_STEP_BITS,
	parameter int CW = 8,
	localparam int NS = (W + F + K - 1) / K,
	localparam int NP = NS * K
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [W-1:0]  in_mag_a,
	input  logic [W-1:0]  in_mag_b,
	input  logic [CW-1:0] in_carry,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [NP-1:0] out_quot,
	output logic [W-1:0]  out_rem,
	output logic [W-1:0]  out_den,
	output logic [CW-1:0] out_carry
);
	logic [NS:0] rdy;

	assign rdy[NS]  = out_ready;
	assign in_ready = rdy[0];

	genvar k;
	for (k = 0; k < NS; k++) begin : g_stage
		logic [W-1:0]  rem_in, den_in, rem_nx;
		logic [NP-1:0] nq_in, nq_nx;
		logic [CW-1:0] carry_in;
		logic          valid_in;
		// nq holds unused dividend bits on top and finished quotient bits below
		logic [W-1:0]  rem_s, den_s;
		logic [NP-1:0] nq_s;
		logic [CW-1:0] carry_s;
		logic          valid_s;

		if (k == 0) begin : g_first
			assign rem_in   = '0;
			assign nq_in    = NP'(in_mag_a) << F;
			assign den_in   = in_mag_b;
			assign carry_in = in_carry;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = g_stage[k-1].rem_s;
			assign nq_in    = g_stage[k-1].nq_s;
			assign den_in   = g_stage[k-1].den_s;
			assign carry_in = g_stage[k-1].carry_s;
			assign valid_in = g_stage[k-1].valid_s;
		end

		assign rdy[k] = !valid_s || rdy[k+1];

		always_comb begin
			logic [W:0] r2;
			rem_nx = rem_in;
			nq_nx  = nq_in;
			for (int j = 0; j < K; j++) begin
				r2    = {rem_nx, nq_nx[NP-1]};
				nq_nx = nq_nx << 1;
				if (r2 >= {1'b0, den_in}) begin
					rem_nx   = W'(r2 - {1'b0, den_in});
					nq_nx[0] = 1'b1;
				end else begin
					rem_nx = r2[W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s <= 1'b0;
			end else if (rdy[k]) begin
				valid_s <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && valid_in) begin
				rem_s   <= rem_nx;
				nq_s    <= nq_nx;
				den_s   <= den_in;
				carry_s <= carry_in;
			end
		end
	end

	assign out_valid = g_stage[NS-1].valid_s;
	assign out_quot  = g_stage[NS-1].nq_s;
	assign out_rem   = g_stage[NS-1].rem_s;
	assign out_den   = g_stage[NS-1].den_s;
	assign out_carry = g_stage[NS-1].carry_s;
endmodule

// File: hw/rtl/fpa_pack.sv
// output stage: quotient rounding, saturation and result selection
// depends on fpa_pkg and assert_macros.svh
`include "assert_macros.svh"
module fpa_pack import fpa_pkg::*; #(
	parameter int W  = WORD_BITS_DEF,
	parameter int NP = 40
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ctl_t          in_ctl,
	input  logic [W-1:0]  in_res,
	input  logic [W:0]    in_mul_prod,
	input  logic          in_mul_big,
	input  logic [NP-1:0] in_quot,
	input  logic [W-1:0]  in_rem,
	input  logic [W-1:0]  in_den,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [W-1:0]  out_res,
	output logic          out_cond,
	output err_t          out_err
);
	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};
	localparam logic [W:0]   LIM   = (W+1)'(1) << (W-1);

	logic          rnd, big, ovf, en;
	logic [NP+1:0] qr;
	logic [W:0]    mag;
	logic [W-1:0]  val, res;
	err_t          err;
	logic          cond;
	logic          valid_s;
	logic [W-1:0]  res_s;
	logic          cond_s;
	err_t          err_s;

	// round half away from zero: bump when twice the remainder reaches the divisor
	assign rnd = {in_rem, 1'b0} >= {1'b0, in_den};
	assign qr  = (NP+2)'(in_quot) + (NP+2)'(rnd);

	always_comb begin
		if (in_ctl.op == OP_MUL) begin
			mag = in_mul_prod;
			big = in_mul_big;
		end else begin
			mag = qr[W:0];
			big = (qr >> (W + 1)) != '0;
		end
		if (in_ctl.neg) begin
			ovf = big || (mag > LIM);
			val = ovf ? MIN_V : W'((W+1)'(0) - mag);
		end else begin
			ovf = big || (mag > LIM - (W+1)'(1));
			val = ovf ? MAX_V : mag[W-1:0];
		end
		res  = in_res;
		cond = in_ctl.cond;
		err  = in_ctl.err;
		case (in_ctl.op) inside
			OP_MUL, OP_DIV: begin
				if (in_ctl.op == OP_DIV && in_ctl.dz) begin
					res = in_ctl.a_neg ? MIN_V : MAX_V;
					err = ERR_DZ;
				end else begin
					res = val;
					err = ovf ? ERR_OVF : ERR_NONE;
				end
			end
			default: res = in_res;
		endcase
	end

	assign en       = !valid_s || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			res_s  <= res;
			cond_s <= cond;
			err_s  <= err;
		end
	end

	assign out_valid = valid_s;
	assign out_res   = res_s;
	assign out_cond  = cond_s;
	assign out_err   = err_s;

	`FPA_ASSERT(a_ovf_saturates, (valid_s && err_s == ERR_OVF |-> res_s == MAX_V || res_s == MIN_V))
	`FPA_ASSERT(a_div_zero_flag, (en && in_valid && in_ctl.op == OP_DIV && in_ctl.dz |=> err_s == ERR_DZ))
	`FPA_NEVER(a_cond_clean, valid_s && cond_s && (err_s != ERR_NONE || res_s != '0))
endmodule
